/* hw/rtl/des_ks_pkg.sv */
// DES key schedule package: permutation tables, rotation schedule and shared types.
`timescale 1ns / 1ps
`default_nettype none

package des_ks_pkg;

	localparam int HALF_W   = 28;
	localparam int KEY_W    = 64;
	localparam int SEL_W    = 56;
	localparam int SUBKEY_W = 48;
	localparam int ROUND_W  = 4;

	localparam logic [ROUND_W-1:0] LAST_ROUND = 4'd15;

	// Bit r set: round r rotates both halves by two places, else by one
	localparam logic [15:0] ROT_TWO = 16'b0111_1110_1111_1100;

	// Key selection permutation: key bit positions, the MSB is position one
	localparam logic [6:0] PC1_TAB [SEL_W] = '{
		7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,  7'd58, 7'd50,
		7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35,
		7'd27, 7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36, 7'd63, 7'd55,
		7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7,  7'd62, 7'd54, 7'd46, 7'd38,
		7'd30, 7'd22, 7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21,
		7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
	};

	// Subkey compression permutation: C:D bit positions, the MSB is position one
	localparam logic [5:0] PC2_TAB [SUBKEY_W] = '{
		6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,  6'd3,  6'd28, 6'd15, 6'd6,
		6'd21, 6'd10, 6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,  6'd16, 6'd7,
		6'd27, 6'd20, 6'd13, 6'd2,  6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55,
		6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48, 6'd44, 6'd49, 6'd39, 6'd56,
		6'd34, 6'd53, 6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
	};

	// Control from the top level to the round engine
	typedef struct packed {
		logic load;
		logic step;
	} ks_ctrl_t;

	// One round result from the engine
	typedef struct packed {
		logic [SUBKEY_W-1:0] subkey;
		logic [ROUND_W-1:0]  round;
		logic                last;
	} ks_result_t;

	// Engine status
	typedef struct packed {
		logic busy;
		logic at_last;
	} ks_status_t;

	function automatic logic [SEL_W-1:0] pc1(input logic [KEY_W-1:0] key);
		logic [SEL_W-1:0] sel;
		sel = '0;
		for (int i = 0; i < SEL_W; i++) begin
			sel[SEL_W-1-i] = key[KEY_W - int'(PC1_TAB[i])];
		end
		return sel;
	endfunction

	function automatic logic [SUBKEY_W-1:0] pc2(input logic [SEL_W-1:0] cd);
		logic [SUBKEY_W-1:0] sk;
		sk = '0;
		for (int i = 0; i < SUBKEY_W; i++) begin
			sk[SUBKEY_W-1-i] = cd[SEL_W - int'(PC2_TAB[i])];
		end
		return sk;
	endfunction

	function automatic logic [HALF_W-1:0] rotl28(input logic [HALF_W-1:0] v,
		input logic two);
		return two ? {v[HALF_W-3:0], v[HALF_W-1:HALF_W-2]}
		           : {v[HALF_W-2:0], v[HALF_W-1]};
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/des_ks_engine.sv */
// DES key schedule round engine: C/D half registers, round counter, rotate and PC2.
`timescale 1ns / 1ps
`default_nettype none

module des_ks_engine (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire des_ks_pkg::ks_ctrl_t          ctrl,
	input  wire logic [des_ks_pkg::KEY_W-1:0]  key,
	output des_ks_pkg::ks_result_t             result,
	output des_ks_pkg::ks_status_t             status
);

	logic [des_ks_pkg::HALF_W-1:0]  c_q, d_q;
	logic [des_ks_pkg::ROUND_W-1:0] round_q;
	logic                           busy_q;

	logic [des_ks_pkg::SEL_W-1:0]   sel;
	logic [des_ks_pkg::HALF_W-1:0]  c_rot, d_rot;
	logic                           rot_two;

	// Next round's rotated halves and subkey
	always_comb begin
		sel     = des_ks_pkg::pc1(key);
		rot_two = des_ks_pkg::ROT_TWO[round_q];
		c_rot   = des_ks_pkg::rotl28(c_q, rot_two);
		d_rot   = des_ks_pkg::rotl28(d_q, rot_two);
	end

	assign result.subkey = des_ks_pkg::pc2({c_rot, d_rot});
	assign result.round  = round_q;
	assign result.last   = (round_q == des_ks_pkg::LAST_ROUND);

	assign status.busy    = busy_q;
	assign status.at_last = busy_q && (round_q == des_ks_pkg::LAST_ROUND);

	// Control: a load restarts at round 0; stepping past the last round goes idle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			round_q <= '0;
		end else if (ctrl.load) begin
			busy_q  <= 1'b1;
			round_q <= '0;
		end else if (ctrl.step) begin
			busy_q  <= (round_q != des_ks_pkg::LAST_ROUND);
			round_q <= round_q + 1'b1;
		end
	end

	// Key halves: load takes priority over a final step in the same cycle
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			c_q <= sel[des_ks_pkg::SEL_W-1:des_ks_pkg::HALF_W];
			d_q <= sel[des_ks_pkg::HALF_W-1:0];
		end else if (ctrl.step) begin
			c_q <= c_rot;
			d_q <= d_rot;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/des_key_schedule_unit.sv */
// DES key schedule top level: handshakes, order register and result register.
//
//  channel  | signals                          | transfer when
//  ---------+----------------------------------+---------------------------
//  input    | in_valid, in_ready, key_in       | in_valid && in_ready
//  output   | out_valid, out_ready, subkey,    | out_valid && out_ready
//           | slot, last                       |
//  config   | cfg_we, cfg_wdata                | cfg_we
//
// One key yields sixteen subkeys, one per cycle unless out_ready stalls; the
// round engine steps once per cycle while the result register can drain.
// The next key is taken during the sixteenth round, so keys stream back to back.
// A stall on out_ready holds the result register and freezes the engine.
// Reset clears the order register, the engine's round counter and busy flag, and the result valid flag.
`timescale 1ns / 1ps
`default_nettype none

module des_key_schedule_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output      logic        in_ready,
	input  wire logic [63:0] key_in,
	output      logic        out_valid,
	input  wire logic        out_ready,
	output      logic [47:0] subkey,
	output      logic [3:0]  slot,
	output      logic        last,
	input  wire logic        cfg_we,
	input  wire logic        cfg_wdata
);

	logic                       decrypt_order_q;
	logic                       out_valid_q;
	logic [47:0]                subkey_q;
	logic [3:0]                 slot_q;
	logic                       last_q;

	logic                       adv;
	des_ks_pkg::ks_ctrl_t       ctrl;
	des_ks_pkg::ks_result_t     result;
	des_ks_pkg::ks_status_t     status;

	// Result register can take a new value when empty or draining
	assign adv       = !out_valid_q || out_ready;
	assign in_ready  = !status.busy || (status.at_last && adv);
	assign ctrl.load = in_valid && in_ready;
	assign ctrl.step = status.busy && adv;

	des_ks_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.key    (key_in),
		.result (result),
		.status (status)
	);

	// Subkey order register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decrypt_order_q <= 1'b0;
		end else if (cfg_we) begin
			decrypt_order_q <= cfg_wdata;
		end
	end

	// Result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload; reversed slot is 15 - round
	always_ff @(posedge clk) begin
		if (ctrl.step) begin
			subkey_q <= result.subkey;
			slot_q   <= result.round ^ {4{decrypt_order_q}};
			last_q   <= result.last;
		end
	end

	assign out_valid = out_valid_q;
	assign subkey    = subkey_q;
	assign slot      = slot_q;
	assign last      = last_q;

endmodule

`default_nettype wire

/* test/des_key_schedule_unit_tb.sv */
// Testbench for des_key_schedule_unit: DES subkey predictor, scoreboard and test sequence.
`timescale 1ns / 1ps

module des_key_schedule_unit_tb;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int SETTLE_CYCLES = 40;

	// Permuted choice 1: key bit positions, 1 = MSB
	localparam int PC1_POS [56] = '{
		57, 49, 41, 33, 25, 17, 9,  1,  58, 50, 42, 34, 26, 18,
		10, 2,  59, 51, 43, 35, 27, 19, 11, 3,  60, 52, 44, 36,
		63, 55, 47, 39, 31, 23, 15, 7,  62, 54, 46, 38, 30, 22,
		14, 6,  61, 53, 45, 37, 29, 21, 13, 5,  28, 20, 12, 4
	};

	// Permuted choice 2: C:D bit positions, 1 = MSB
	localparam int PC2_POS [48] = '{
		14, 17, 11, 24, 1,  5,  3,  28, 15, 6,  21, 10,
		23, 19, 12, 4,  26, 8,  16, 7,  27, 20, 13, 2,
		41, 52, 31, 37, 47, 55, 30, 40, 51, 45, 33, 48,
		44, 49, 39, 56, 34, 53, 46, 42, 50, 36, 29, 32
	};

	// Left rotation of both halves before each round
	localparam int ROT_AMT [16] = '{1, 1, 2, 2, 2, 2, 2, 2, 1, 2, 2, 2, 2, 2, 2, 1};

	typedef struct packed {
		logic [47:0] subkey;
		logic [3:0]  slot;
		logic        last;
	} round_key_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [63:0] key_in;
	logic        out_valid;
	logic        out_ready;
	logic [47:0] subkey;
	logic [3:0]  slot;
	logic        last;
	logic        cfg_we;
	logic        cfg_wdata;

	round_key_t pending_subkeys [$];
	bit         order_shadow;
	int         mismatches;
	int         cycle_count;

	// sender and receiver pacing
	bit stalls_on;
	bit gaps_on;
	int burst_left;
	int hold_cycles;
	int run_left;
	bit run_ready;

	des_key_schedule_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.key_in   (key_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.subkey   (subkey),
		.slot     (slot),
		.last     (last),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #1 clk = ~clk;

	// Run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Expand one key into its sixteen expected subkeys
	function automatic void expand_key(input logic [63:0] k);
		logic [55:0] sel;
		logic [27:0] c;
		logic [27:0] d;
		logic [55:0] cd;
		round_key_t  rk;
		for (int i = 0; i < 56; i++)
			sel[55-i] = k[64-PC1_POS[i]];
		c = sel[55:28];
		d = sel[27:0];
		for (int r = 0; r < 16; r++) begin
			for (int s = 0; s < ROT_AMT[r]; s++) begin
				c = {c[26:0], c[27]};
				d = {d[26:0], d[27]};
			end
			cd = {c, d};
			for (int i = 0; i < 48; i++)
				rk.subkey[47-i] = cd[56-PC2_POS[i]];
			rk.slot = order_shadow ? 4'(15 - r) : 4'(r);
			rk.last = (r == 15);
			pending_subkeys.push_back(rk);
		end
	endfunction

	// Receiver: long hold when requested, else always ready, or random ready/stall runs with stalls on
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles--;
			out_ready <= 1'b0;
		end else if (!stalls_on) begin
			out_ready <= 1'b1;
		end else begin
			if (run_left == 0) begin
				run_ready = !run_ready;
				run_left = run_ready ? $urandom_range(1, 12) : $urandom_range(1, 6);
			end
			run_left--;
			out_ready <= run_ready;
		end
	end

	// Scoreboard: each output transfer against the oldest pending subkey
	always @(posedge clk) begin
		round_key_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_subkeys.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected subkey %h slot %0d last %b", subkey, slot, last);
			end else begin
				want = pending_subkeys.pop_front();
				if (subkey !== want.subkey || slot !== want.slot || last !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp subkey %h slot %0d last %b, got %h %0d %b",
							want.subkey, want.slot, want.last, subkey, slot, last);
				end
			end
		end
	end

	// Gap after a transfer: none with gaps off, else bursts of back-to-back keys, random gaps between
	function automatic int pick_gap();
		if (!gaps_on)
			return 0;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		burst_left = $urandom_range(0, 6);
		return $urandom_range(1, 24);
	endfunction

	// One key transfer; closes forces valid low afterwards
	task automatic send_key(input logic [63:0] k, input bit closes);
		int gap;
		@(negedge clk);
		in_valid <= 1'b1;
		key_in   <= k;
		do @(posedge clk); while (!in_ready);
		expand_key(k);
		gap = pick_gap();
		if (closes && gap == 0)
			gap = 1;
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic wait_for_subkeys();
		while (pending_subkeys.size() != 0)
			@(posedge clk);
	endtask

	// Order register write, only with the block idle
	task automatic write_order(input bit v);
		wait_for_subkeys();
		repeat (20) @(posedge clk);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		order_shadow = v;
	endtask

	task automatic test_reference_keys();
		write_order(1'b0);
		send_key(64'h1334_5779_9BBC_DFF1, 1'b0);
		send_key(64'h0000_0000_0000_0000, 1'b0);
		send_key(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
		send_key(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
		send_key(64'h5555_5555_5555_5555, 1'b0);
		send_key(64'h8000_0000_0000_0000, 1'b0);
		send_key(64'h0000_0000_0000_0002, 1'b1);
	endtask

	// Parity bits must not matter; weak and semi-weak keys get no special path
	task automatic test_parity_and_weak();
		send_key(64'h0101_0101_0101_0101, 1'b0);
		send_key(64'hFEFE_FEFE_FEFE_FEFE, 1'b0);
		send_key(64'h1334_5779_9BBC_DFF1 ^ 64'h0101_0101_0101_0101, 1'b0);
		send_key(64'h1F1F_1F1F_0E0E_0E0E, 1'b0);
		send_key(64'hE0E0_E0E0_F1F1_F1F1, 1'b0);
		send_key(64'h01FE_01FE_01FE_01FE, 1'b1);
	endtask

	task automatic test_decrypt_order();
		write_order(1'b1);
		send_key(64'h1334_5779_9BBC_DFF1, 1'b0);
		send_key(64'h0123_4567_89AB_CDEF, 1'b0);
		send_key(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
		write_order(1'b0);
		send_key(64'h0123_4567_89AB_CDEF, 1'b1);
	endtask

	// Back-to-back keys with the receiver always ready
	task automatic test_streaming();
		stalls_on = 1'b0;
		gaps_on   = 1'b0;
		for (int i = 0; i < 8; i++)
			send_key({$urandom, $urandom}, i == 7);
		wait_for_subkeys();
	endtask

	// Receiver holds off long enough for the block to stall its input
	task automatic test_output_hold();
		gaps_on = 1'b0;
		@(posedge clk);
		hold_cycles = 300;
		for (int i = 0; i < 6; i++)
			send_key({$urandom, $urandom}, i == 5);
		wait_for_subkeys();
	endtask

	// Sender waits for every subkey mid-stream, then resumes
	task automatic test_drained_pause();
		stalls_on = 1'b1;
		gaps_on   = 1'b1;
		for (int i = 0; i < 4; i++)
			send_key({$urandom, $urandom}, i == 3);
		wait_for_subkeys();
		for (int i = 0; i < 4; i++)
			send_key({$urandom, $urandom}, i == 3);
	endtask

	// Random keys in chunks, each with its own pacing and sometimes a new order
	task automatic test_random_keys();
		logic [63:0] k;
		for (int chunk = 0; chunk < 7; chunk++) begin
			if ($urandom_range(0, 2) == 0)
				write_order(1'($urandom_range(0, 1)));
			stalls_on = ($urandom_range(0, 3) != 0);
			gaps_on   = ($urandom_range(0, 3) != 0);
			for (int j = 0; j < 17; j++) begin
				case ($urandom_range(0, 7))
					0: k = 64'd1 << $urandom_range(0, 63);
					1: k = ~(64'd1 << $urandom_range(0, 63));
					default: k = {$urandom, $urandom};
				endcase
				send_key(k, j == 16);
			end
		end
		// make sure both orders end up exercised by random keys
		write_order(!order_shadow);
		for (int j = 0; j < 6; j++)
			send_key({$urandom, $urandom}, j == 5);
	endtask

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		key_in      = '0;
		out_ready   = 1'b0;
		cfg_we      = 1'b0;
		cfg_wdata   = 1'b0;
		order_shadow = 1'b0;
		mismatches  = 0;
		cycle_count = 0;
		stalls_on   = 1'b0;
		gaps_on     = 1'b1;
		burst_left  = 0;
		hold_cycles = 0;
		run_left    = 0;
		run_ready   = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reference_keys();
		test_parity_and_weak();
		test_decrypt_order();
		test_streaming();
		test_output_hold();
		test_drained_pause();
		test_random_keys();

		wait_for_subkeys();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_subkeys.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
